// File: rtl/core/counting_semaphore_table_assert.svh
// assertion macros for the semaphore table
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked during reset as well
`define CST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CST_ASSERT(lbl, prop, msg)
`define CST_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/core/cst_pkg.sv
package cst_pkg;

  // count is a 16-bit two's complement value
  localparam int COUNT_W = 16;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  // stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_DOWN   = 2'd1,
    FN_UP     = 2'd2,
    FN_CLOSE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_ROOM  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // decisions of the update unit for one found slot
  typedef struct packed {
    status_t status;
    logic    must_sleep;
    logic    wake;
    logic    wr_slot;
    logic    wr_wait;
    logic    clear_valid;
  } alu_flags_t;

endpackage

// File: rtl/core/cst_ram.sv
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cst_alu.sv
module cst_alu #(
  parameter int SEM_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 16,
  localparam int SB  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1,
  localparam int QB  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int WAB = (SEM_SLOTS * QUEUE_DEPTH > 1) ? $clog2(SEM_SLOTS * QUEUE_DEPTH) : 1
) (
  input  cst_pkg::func_t                    func,
  input  logic signed [cst_pkg::COUNT_W-1:0] count,
  input  logic [QB-1:0]                     head,
  input  logic [SB-1:0]                     slot,
  output logic signed [cst_pkg::COUNT_W-1:0] cnt_nxt,
  output logic [QB-1:0]                     head_nxt,
  output logic [WAB-1:0]                    wq_addr,
  output cst_pkg::alu_flags_t               flags
);

  import cst_pkg::*;

  logic signed [COUNT_W-1:0] neg_count;
  logic [COUNT_W-1:0]        waiters;
  logic [QB:0]               tail_sum;
  logic [QB-1:0]             tail_pos;
  logic [QB-1:0]             sel_pos;

  // waiters is minus the count when the count is negative
  assign neg_count = -count;
  assign waiters   = (count < 0) ? neg_count : '0;

  // tail position wraps around the queue with one compare and subtract
  assign tail_sum = {1'b0, head} + (QB+1)'(waiters);
  assign tail_pos = (tail_sum >= (QB+1)'(QUEUE_DEPTH)) ?
                    QB'(tail_sum - (QB+1)'(QUEUE_DEPTH)) : QB'(tail_sum);

  // down writes at the tail, up reads at the head
  assign sel_pos = (func == FN_DOWN) ? tail_pos : head;
  assign wq_addr = WAB'(slot) * WAB'(QUEUE_DEPTH) + WAB'(sel_pos);

  // count update and decisions per operation
  always_comb begin
    cnt_nxt  = count;
    head_nxt = head;
    flags    = '{status: ST_OK, default: 1'b0};
    unique case (func)
      FN_DOWN: begin
        if (count <= 0) begin
          if (waiters >= COUNT_W'(QUEUE_DEPTH)) begin
            flags.status = ST_NO_ROOM;
          end else begin
            cnt_nxt          = count - 16'sd1;
            flags.wr_slot    = 1'b1;
            flags.wr_wait    = 1'b1;
            flags.must_sleep = 1'b1;
          end
        end else begin
          cnt_nxt       = count - 16'sd1;
          flags.wr_slot = 1'b1;
        end
      end
      FN_UP: begin
        if (count >= COUNT_MAX) begin
          flags.status = ST_OVERFLOW;
        end else begin
          cnt_nxt       = count + 16'sd1;
          flags.wr_slot = 1'b1;
          if (count < 0) begin
            flags.wake = 1'b1;
            head_nxt   = (head == QB'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          end
        end
      end
      FN_CLOSE: begin
        if (count < 0) begin
          flags.status = ST_INVALID;
        end else begin
          flags.clear_valid = 1'b1;
        end
      end
      FN_CREATE: begin
        flags.status = ST_OK;
      end
      default: begin
        flags.status = ST_OK;
      end
    endcase
  end

endmodule

// File: rtl/core/counting_semaphore_table.sv
// create: the free-slot scan over the valid bits, one slot a cycle, then the update step
// when a slot is free, and the response step
// down, up and close: the id scan through the slot ram read port, one slot a cycle, then
// the update step on a match, a queue read when up reads the wait queue, then the response
// flow: the next transfer in comes after the last result is registered, even while it waits
// reset: synchronous active low, clears valid bits and id counter at once, no clear pass
`include "counting_semaphore_table_assert.svh"

module counting_semaphore_table #(
  parameter int SEM_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS   = 8,
  parameter int ID_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sem_id[15:0], init_value[30:16], task_id[38:31], zero[39]
  input  logic [cst_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], new_id[17:2], must_sleep[18], woken_valid[19], woken_task[27:20], zero[31:28]
  output logic [cst_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import cst_pkg::*;

  localparam int SB     = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int QB     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WAB    = (SEM_SLOTS * QUEUE_DEPTH > 1) ? $clog2(SEM_SLOTS * QUEUE_DEPTH) : 1;
  localparam int SLOT_W = ID_BITS + COUNT_W + QB;
  localparam int CMPW   = (ID_BITS > 16) ? ID_BITS : 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_WAKE,
    S_RESP
  } state_t;

  state_t                    state_r;
  logic [SEM_SLOTS-1:0]      valid_r;
  logic [ID_BITS-1:0]        next_ident_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  func_t                     func_r;
  logic [15:0]               sem_r;
  logic [14:0]               init_r;
  logic [7:0]                task_r;

  logic [SB:0]               idx_r;
  logic                      chk_vld_r;
  logic [SB-1:0]             chk_idx_r;
  logic [SB-1:0]             slot_r;
  logic [ID_BITS-1:0]        ident_r;
  logic signed [COUNT_W-1:0] cnt_r;
  logic [QB-1:0]             head_r;

  status_t                   res_status_r;
  logic [15:0]               res_new_id_r;
  logic                      res_sleep_r;
  logic                      res_wake_r;
  logic [7:0]                res_task_r;

  logic                      slot_we;
  logic [SLOT_W-1:0]         slot_wdata;
  logic [SLOT_W-1:0]         slot_rdata;
  logic [ID_BITS-1:0]        rd_ident;
  logic signed [COUNT_W-1:0] rd_count;
  logic [QB-1:0]             rd_head;

  logic                      wq_we;
  logic [TASK_BITS-1:0]      wq_rdata;

  logic signed [COUNT_W-1:0] alu_cnt;
  logic [QB-1:0]             alu_head;
  logic [WAB-1:0]            alu_addr;
  alu_flags_t                alu_flags;

  logic                      issue_ok;
  logic                      match;
  logic                      last_chk;
  logic                      free_slot;
  logic                      last_free;
  logic                      out_free;
  logic                      resp_fire;

  // handshake
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign resp_fire  = (state_r == S_RESP) && out_free;

  // slot ram word fields
  assign rd_ident = slot_rdata[SLOT_W-1 -: ID_BITS];
  assign rd_count = slot_rdata[QB +: COUNT_W];
  assign rd_head  = slot_rdata[QB-1:0];

  // id scan: one read issued per cycle, compared in the cycle after
  assign issue_ok = (idx_r < (SB+1)'(SEM_SLOTS));
  assign match    = chk_vld_r && valid_r[chk_idx_r] &&
                    (CMPW'(rd_ident) == CMPW'(sem_r));
  assign last_chk = (chk_idx_r == SB'(SEM_SLOTS - 1));

  // free slot scan over the valid bits
  assign free_slot = !valid_r[idx_r[SB-1:0]];
  assign last_free = (idx_r[SB-1:0] == SB'(SEM_SLOTS - 1));

  // slot ram write: full word on create, count and head otherwise
  assign slot_we    = (state_r == S_EXEC) && ((func_r == FN_CREATE) || alu_flags.wr_slot);
  assign slot_wdata = (func_r == FN_CREATE) ?
                      {next_ident_r, COUNT_W'(init_r), {QB{1'b0}}} :
                      {ident_r, alu_cnt, alu_head};

  assign wq_we = (state_r == S_EXEC) && alu_flags.wr_wait;

  cst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SEM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_r),
    .wdata (slot_wdata),
    .raddr (idx_r[SB-1:0]),
    .rdata (slot_rdata)
  );

  cst_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (SEM_SLOTS * QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (wq_we),
    .waddr (alu_addr),
    .wdata (TASK_BITS'(task_r)),
    .raddr (alu_addr),
    .rdata (wq_rdata)
  );

  cst_alu #(
    .SEM_SLOTS   (SEM_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_alu (
    .func     (func_r),
    .count    (cnt_r),
    .head     (head_r),
    .slot     (slot_r),
    .cnt_nxt  (alu_cnt),
    .head_nxt (alu_head),
    .wq_addr  (alu_addr),
    .flags    (alu_flags)
  );

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      next_ident_r <= '0;
      out_valid_r  <= 1'b0;
      chk_vld_r    <= 1'b0;
    end else begin
      // result register: load on the response step, drop after its transfer out
      if (resp_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r       <= func_t'(in_tuser);
            sem_r        <= in_tdata[15:0];
            init_r       <= in_tdata[30:16];
            task_r       <= in_tdata[38:31];
            idx_r        <= '0;
            chk_vld_r    <= 1'b0;
            res_status_r <= ST_OK;
            res_new_id_r <= '0;
            res_sleep_r  <= 1'b0;
            res_wake_r   <= 1'b0;
            res_task_r   <= '0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (func_r == FN_CREATE) begin
            if (free_slot) begin
              slot_r  <= idx_r[SB-1:0];
              state_r <= S_EXEC;
            end else if (last_free) begin
              res_status_r <= ST_NO_ROOM;
              state_r      <= S_RESP;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            chk_vld_r <= issue_ok;
            chk_idx_r <= idx_r[SB-1:0];
            if (issue_ok) begin
              idx_r <= idx_r + 1'b1;
            end
            if (match) begin
              slot_r  <= chk_idx_r;
              ident_r <= rd_ident;
              cnt_r   <= rd_count;
              head_r  <= rd_head;
              state_r <= S_EXEC;
            end else if (chk_vld_r && last_chk) begin
              res_status_r <= ST_INVALID;
              state_r      <= S_RESP;
            end
          end
        end
        S_EXEC: begin
          if (func_r == FN_CREATE) begin
            valid_r[slot_r] <= 1'b1;
            res_new_id_r    <= 16'(next_ident_r);
            next_ident_r    <= next_ident_r + 1'b1;
            state_r         <= S_RESP;
          end else begin
            res_status_r <= alu_flags.status;
            res_sleep_r  <= alu_flags.must_sleep;
            res_wake_r   <= alu_flags.wake;
            if (alu_flags.clear_valid) begin
              valid_r[slot_r] <= 1'b0;
            end
            state_r <= alu_flags.wake ? S_WAKE : S_RESP;
          end
        end
        S_WAKE: begin
          res_task_r <= 8'(wq_rdata);
          state_r    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r  <= {4'b0000, res_task_r, res_wake_r, res_sleep_r,
                            res_new_id_r, res_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CST_ASSERT(a_accept_scan, (in_tvalid && in_tready) |=> (state_r == S_SCAN),
              "transfer in did not start a scan")
  `CST_ASSERT(a_wake_after_exec, (state_r == S_WAKE) |-> ($past(state_r) == S_EXEC),
              "queue read without update step")
  `CST_ASSERT(a_sleep_xor_wake, out_valid_r |-> !(out_data_r[18] && out_data_r[19]),
              "result both sleeps and wakes")
  `CST_ASSERT(a_overflow_no_wake,
              (out_valid_r && (out_data_r[1:0] == ST_OVERFLOW)) |-> !out_data_r[19],
              "overflow released a task")
  `CST_ASSERT(a_wq_write_down, wq_we |-> (func_r == FN_DOWN),
              "wait queue written by other than down")
  `CST_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready),
                  "reset left block busy")

endmodule

// File: verif/counting_semaphore_table_tb.sv
`timescale 1ns / 100ps

module counting_semaphore_table_tb;
  import cst_pkg::*;

  localparam int SLOTS = 16;
  localparam int DEPTH = 16;

  // one result of the block
  typedef struct packed {
    status_t    status;
    logic [15:0] new_id;
    logic       must_sleep;
    logic       woken_valid;
    logic [7:0] woken_task;
  } sem_res_t;

  // one row of the directed stimulus
  typedef struct {
    func_t     fn;
    bit [15:0] sem;
    bit [14:0] init;
    bit [7:0]  tsk;
    int        reps;
    bit        typed;
    sem_res_t  res;
  } op_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow of the semaphore table
  logic               m_valid [SLOTS];
  logic [15:0]        m_ident [SLOTS];
  logic signed [15:0] m_count [SLOTS];
  logic [7:0]         m_wait  [SLOTS][DEPTH];
  logic [3:0]         m_head  [SLOTS];
  logic [15:0]        m_next;

  sem_res_t pending_res[$];
  op_row_t  op_rows[$];
  int       err_cnt = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  sem_res_t got_res;
  sem_res_t want_res;

  counting_semaphore_table #(
    .SEM_SLOTS  (SLOTS),
    .QUEUE_DEPTH(DEPTH),
    .TASK_BITS  (8),
    .ID_BITS    (16)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("counting_semaphore_table test failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // apply one operation to the shadow table and return its result
  function automatic sem_res_t apply_sem_op(func_t fn, bit [15:0] sem, bit [14:0] init,
                                            bit [7:0] tsk);
    sem_res_t r;
    int       s;
    int       c;
    int       waiters;
    int       pos;
    r = '0;
    r.status = ST_OK;
    s = -1;
    if (fn == FN_CREATE) begin
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && !m_valid[i]) s = i;
      if (s < 0) begin
        r.status = ST_NO_ROOM;
      end else begin
        m_valid[s] = 1'b1;
        m_ident[s] = m_next;
        m_count[s] = {1'b0, init};
        m_head[s]  = '0;
        r.new_id   = m_next;
        m_next     = m_next + 16'd1;
      end
    end else begin
      // lowest matching slot wins when ids repeat
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && m_valid[i] && m_ident[i] == sem) s = i;
      if (s < 0) begin
        r.status = ST_INVALID;
      end else begin
        c = int'(m_count[s]);
        case (fn)
          FN_DOWN: begin
            if (c - 1 < 0) begin
              waiters = (c < 0) ? -c : 0;
              if (waiters >= DEPTH) begin
                r.status = ST_NO_ROOM;
              end else begin
                pos = (int'(m_head[s]) + waiters) % DEPTH;
                m_wait[s][pos] = tsk;
                m_count[s] = 16'(c - 1);
                r.must_sleep = 1'b1;
              end
            end else begin
              m_count[s] = 16'(c - 1);
            end
          end
          FN_UP: begin
            if (c >= COUNT_MAX) begin
              r.status = ST_OVERFLOW;
            end else begin
              m_count[s] = 16'(c + 1);
              if (c + 1 <= 0) begin
                r.woken_task  = m_wait[s][m_head[s]];
                r.woken_valid = 1'b1;
                m_head[s]     = 4'((int'(m_head[s]) + 1) % DEPTH);
              end
            end
          end
          default: begin
            if (c < 0) r.status = ST_INVALID;
            else m_valid[s] = 1'b0;
          end
        endcase
      end
    end
    return r;
  endfunction

  // present one item, wait for its transfer, then record the expected result
  task automatic send_op(func_t fn, bit [15:0] sem, bit [14:0] init, bit [7:0] tsk,
                         bit typed = 1'b0, sem_res_t typed_res = '0);
    sem_res_t r;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tsk, init, sem};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_sem_op(fn, sem, init, tsk);
    pending_res.push_back(typed ? typed_res : r);
  endtask

  // stop sending and hold off until every result is back
  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(func_t fn, bit [15:0] sem, bit [14:0] init, bit [7:0] tsk,
                                  int reps = 1, bit typed = 1'b0, status_t st = ST_OK,
                                  bit [15:0] nid = '0, bit slp = 1'b0, bit wv = 1'b0,
                                  bit [7:0] wt = '0);
    op_row_t row;
    row.fn    = fn;
    row.sem   = sem;
    row.init  = init;
    row.tsk   = tsk;
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{status: st, new_id: nid, must_sleep: slp, woken_valid: wv, woken_task: wt};
    op_rows.push_back(row);
  endfunction

  // random item, mostly aimed at live semaphores
  task automatic send_random_op();
    int        r;
    int        s;
    bit        hit;
    func_t     fn;
    bit [15:0] sem;
    bit [14:0] init;
    bit [7:0]  tsk;
    r = $urandom_range(99);
    if (r < 20) fn = FN_CREATE;
    else if (r < 52) fn = FN_DOWN;
    else if (r < 85) fn = FN_UP;
    else fn = FN_CLOSE;
    sem = 16'($urandom);
    if ($urandom_range(99) < 85) begin
      s = $urandom_range(SLOTS - 1);
      hit = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        if (!hit && m_valid[(s + k) % SLOTS]) begin
          sem = m_ident[(s + k) % SLOTS];
          hit = 1'b1;
        end
      end
    end
    r = $urandom_range(9);
    if (r < 6) init = 15'($urandom_range(3));
    else if (r == 6) init = 15'h7fff;
    else if (r == 7) init = 15'h7ffe;
    else init = 15'($urandom);
    tsk = 8'($urandom);
    send_op(fn, sem, init, tsk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.status      = status_t'(out_tdata[1:0]);
      got_res.new_id      = out_tdata[17:2];
      got_res.must_sleep  = out_tdata[18];
      got_res.woken_valid = out_tdata[19];
      got_res.woken_task  = out_tdata[27:20];
      if (pending_res.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, data %h", out_tdata));
      end else begin
        want_res = pending_res.pop_front();
        if (got_res.status !== want_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", got_res.status,
                                    want_res.status));
        if (got_res.new_id !== want_res.new_id)
          report_mismatch($sformatf("new_id %h, expected %h", got_res.new_id,
                                    want_res.new_id));
        if (got_res.must_sleep !== want_res.must_sleep)
          report_mismatch($sformatf("must_sleep %b, expected %b", got_res.must_sleep,
                                    want_res.must_sleep));
        if (got_res.woken_valid !== want_res.woken_valid)
          report_mismatch($sformatf("woken_valid %b, expected %b", got_res.woken_valid,
                                    want_res.woken_valid));
        if (got_res.woken_task !== want_res.woken_task)
          report_mismatch($sformatf("woken_task %h, expected %h", got_res.woken_task,
                                    want_res.woken_task));
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < SLOTS; i++) m_valid[i] = 1'b0;
    m_next = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows: unknown id, extremes, sleeping and waking, full queue, full table
    add_row(FN_DOWN,   16'h0000, 15'h7fff, 8'h00, 1, 1, ST_INVALID);
    add_row(FN_CREATE, 16'hffff, 15'h0000, 8'hff, 1, 1, ST_OK, 16'd0);
    add_row(FN_CREATE, 16'h0000, 15'h7fff, 8'h00, 1, 1, ST_OK, 16'd1);
    add_row(FN_UP,     16'h0001, 15'h0000, 8'h00, 1, 1, ST_OVERFLOW);
    add_row(FN_DOWN,   16'h0001, 15'h5555, 8'h55, 1, 1, ST_OK);
    add_row(FN_DOWN,   16'h0000, 15'h2aaa, 8'hff, 1, 1, ST_OK, 16'd0, 1'b1);
    add_row(FN_CLOSE,  16'h0000, 15'h0000, 8'h00, 1, 1, ST_INVALID);
    add_row(FN_UP,     16'h0000, 15'h0000, 8'h00, 1, 1, ST_OK, 16'd0, 1'b0, 1'b1, 8'hff);
    add_row(FN_DOWN,   16'h0000, 15'h0000, 8'h10, DEPTH);
    add_row(FN_DOWN,   16'h0000, 15'h0000, 8'haa, 1, 1, ST_NO_ROOM);
    add_row(FN_UP,     16'h0000, 15'h0000, 8'h00, DEPTH);
    add_row(FN_CLOSE,  16'h0000, 15'h0000, 8'h00, 1, 1, ST_OK);
    add_row(FN_CLOSE,  16'h0000, 15'h0000, 8'h00, 1, 1, ST_INVALID);
    add_row(FN_UP,     16'hffff, 15'h7fff, 8'hff, 1, 1, ST_INVALID);
    add_row(FN_CREATE, 16'h0000, 15'h0100, 8'h00, SLOTS - 1);
    add_row(FN_CREATE, 16'h0000, 15'h0001, 8'h00, 1, 1, ST_NO_ROOM);
    add_row(FN_CLOSE,  16'h0001, 15'h0000, 8'h00, 1, 1, ST_OK);
    add_row(FN_CREATE, 16'h0000, 15'h2aaa, 8'h00);

    tx_idle_pct = 14;
    rx_idle_pct = 82;
    foreach (op_rows[i]) begin
      for (int k = 0; k < op_rows[i].reps; k++)
        send_op(op_rows[i].fn, op_rows[i].sem, 15'(op_rows[i].init + k),
                8'(op_rows[i].tsk + k), op_rows[i].typed, op_rows[i].res);
    end
    repeat (280) send_random_op();
    wait_results_done();

    tx_idle_pct = 82;
    rx_idle_pct = 14;
    repeat (280) send_random_op();
    wait_results_done();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (230) send_random_op();
    wait_results_done();

    // let any stray result show up
    repeat (SLOTS + 10) @(posedge clk);
    if (pending_res.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
    if (err_cnt == 0) begin
      $display("counting_semaphore_table test passed");
    end else begin
      $display("counting_semaphore_table test failed");
    end
    $finish;
  end

endmodule
